/* rtl/palette_port_clut_assert.svh */
// assertion macros shared by the palette lookup rtl
// both macros expect i_clk and i_rst_n in the enclosing module
`ifndef PALETTE_PORT_CLUT_ASSERT_SVH
`define PALETTE_PORT_CLUT_ASSERT_SVH

// same-cycle implication
`define PCLUT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCLUT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pclut_pkg.sv */
`default_nettype none

package pclut_pkg;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned RGB_W    = 16;
    localparam int unsigned PIX_W    = 8;
    localparam int unsigned ENTRY_W  = 24;
    localparam int unsigned PIX_CODES = 256;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET_INDEX = 2'd0,
        ACT_DATA      = 2'd1,
        ACT_LOOKUP    = 2'd2
    } t_action;

    // lookup in flight between the ram read and the output register
    typedef struct packed {
        logic             fallback;
        logic             entry_valid;
        logic [PIX_W-1:0] pix;
    } t_lookup_req;

endpackage

`default_nettype wire

/* rtl/pclut_in_if.sv */
`default_nettype none

interface pclut_in_if
    import pclut_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

/* rtl/pclut_out_if.sv */
`default_nettype none

interface pclut_out_if
    import pclut_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [RGB_W-1:0] rgb565;
    logic             from_fallback;

    modport source (output valid, output rgb565, output from_fallback, input ready);
    modport sink   (input valid, input rgb565, input from_fallback, output ready);
endinterface

`default_nettype wire

/* rtl/pclut_ram.sv */
`default_nettype none

module pclut_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/pclut_lookup.sv */
`default_nettype none

`include "palette_port_clut_assert.svh"

module pclut_lookup
    import pclut_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    input  wire t_lookup_req        i_req,
    input  wire logic [ENTRY_W-1:0] i_rdata,
    output logic                    o_req_ready,
    pclut_out_if.source             o_out
);

    logic             r_s1_valid, n_s1_valid;
    t_lookup_req      r_s1_req;
    logic             r_out_valid, n_out_valid;
    logic [RGB_W-1:0] r_rgb, n_rgb;
    logic             r_fb, n_fb;
    logic             w_out_load;
    logic [ENTRY_W-1:0] w_entry;

    assign w_out_load  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign o_req_ready = !r_s1_valid || w_out_load;

    // never-written entries read as zero
    assign w_entry = r_s1_req.entry_valid ? i_rdata : '0;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        n_rgb       = r_rgb;
        n_fb        = r_fb;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_out_load) begin
            n_s1_valid  = 1'b0;
            n_out_valid = 1'b1;
            n_fb        = r_s1_req.fallback;
            if (r_s1_req.fallback) begin
                n_rgb = {r_s1_req.pix[7:5], 2'b00, r_s1_req.pix[4:2], 3'b000,
                         r_s1_req.pix[1:0], 3'b000};
            end else begin
                n_rgb = {w_entry[23:19], w_entry[15:10], w_entry[7:3]};
            end
        end
        if (i_req_valid) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
        if (i_req_valid) begin
            r_s1_req <= i_req;
        end
        r_rgb <= n_rgb;
        r_fb  <= n_fb;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.rgb565        = r_rgb;
    assign o_out.from_fallback = r_fb;

    `PCLUT_ASSERT_NEXT(a_s1_drains, w_out_load, r_out_valid, "lookup result not registered")
    `PCLUT_ASSERT_NOW(a_fb_shape, r_out_valid && r_fb, (r_rgb[12:11] == 2'b00) && (r_rgb[7:5] == 3'b000) && (r_rgb[2:0] == 3'b000), "fallback colour has stray bits")
    `PCLUT_ASSERT_NOW(a_no_overrun, i_req_valid, o_req_ready, "lookup issued while stage busy")

endmodule

`default_nettype wire

/* rtl/palette_port_clut.sv */
// lookup path: ram read and lookup stage registers, then the output register
// throughput: one transaction per cycle unless a lookup waits on a stalled
// output; lookups read the ram once; writes and index updates give no result
// reset (synchronous, active low): control state, upload index and all entry
// valid flags clear at once; no clearing pass, unwritten entries read as zero
`default_nettype none

`include "palette_port_clut_assert.svh"

module palette_port_clut
    import pclut_pkg::*;
#(
    parameter int unsigned ENTRIES = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pclut_in_if.sink    i_in,
    pclut_out_if.source o_out
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);

    logic [IDX_W-1:0]   w_wrap [PIX_CODES];
    logic [IDX_W-1:0]   r_entry_index, n_entry_index;
    logic               r_pair_phase, n_pair_phase;
    logic [15:0]        r_pending_gb, n_pending_gb;
    logic               r_loaded, n_loaded;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic               w_accept;
    logic               w_req_ready;
    logic               w_ram_we;
    logic               w_ram_re;
    logic [IDX_W-1:0]   w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    t_lookup_req        w_req;

    // index reduction table, built at elaboration
    for (genvar k = 0; k < PIX_CODES; k++) begin : g_wrap
        assign w_wrap[k] = IDX_W'(k % ENTRIES);
    end

    assign i_in.ready = w_req_ready;
    assign w_accept   = i_in.valid && w_req_ready;

    assign w_raddr = w_wrap[i_in.value[PIX_W-1:0]];

    always_comb begin
        n_entry_index = r_entry_index;
        n_pair_phase  = r_pair_phase;
        n_pending_gb  = r_pending_gb;
        n_loaded      = r_loaded;
        n_valid       = r_valid;
        w_ram_we      = 1'b0;
        w_ram_re      = 1'b0;
        if (w_accept) begin
            case (i_in.action)
                ACT_SET_INDEX: begin
                    n_entry_index = w_raddr;
                    n_pair_phase  = 1'b0;
                end
                ACT_DATA: begin
                    if (!r_pair_phase) begin
                        n_pending_gb = i_in.value;
                        n_pair_phase = 1'b1;
                    end else begin
                        w_ram_we                = 1'b1;
                        n_valid[r_entry_index]  = 1'b1;
                        n_pair_phase            = 1'b0;
                        n_loaded                = 1'b1;
                        n_entry_index = (r_entry_index == IDX_W'(ENTRIES - 1)) ? '0
                                        : r_entry_index + IDX_W'(1);
                    end
                end
                ACT_LOOKUP: begin
                    w_ram_re = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_index <= '0;
            r_pair_phase  <= 1'b0;
            r_pending_gb  <= '0;
            r_loaded      <= 1'b0;
            r_valid       <= '0;
        end else begin
            r_entry_index <= n_entry_index;
            r_pair_phase  <= n_pair_phase;
            r_pending_gb  <= n_pending_gb;
            r_loaded      <= n_loaded;
            r_valid       <= n_valid;
        end
    end

    // loaded flag and entry validity are sampled with the read address
    assign w_req.fallback    = !r_loaded;
    assign w_req.entry_valid = r_valid[w_raddr];
    assign w_req.pix         = i_in.value[PIX_W-1:0];

    pclut_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_entry_index),
        .i_wdata ({i_in.value[7:0], r_pending_gb}),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pclut_lookup u_lookup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_ram_re),
        .i_req       (w_req),
        .i_rdata     (w_rdata),
        .o_req_ready (w_req_ready),
        .o_out       (o_out)
    );

    `PCLUT_ASSERT_NEXT(a_loaded_sticky, r_loaded, r_loaded, "loaded flag dropped")
    `PCLUT_ASSERT_NEXT(a_index_restarts_pair, w_accept && (i_in.action == ACT_SET_INDEX), !r_pair_phase, "index write left pair open")
    `PCLUT_ASSERT_NEXT(a_write_marks_entry, w_ram_we, r_loaded && r_valid[$past(r_entry_index)], "stored entry not marked valid")

endmodule

`default_nettype wire

/* bench/testbench.sv */
`default_nettype none

module testbench;
    import pclut_pkg::*;

    localparam int unsigned CLUT_ENTRIES   = 256;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int unsigned RANDOM_ITEMS   = 860;
    localparam int unsigned BURST_LOOKUPS  = 160;
    localparam int unsigned STALL_CYCLES   = 300;
    localparam int unsigned DRAIN_CYCLES   = 6;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [RGB_W-1:0] rgb565;
        logic             from_fallback;
    } t_colour_result;

    logic i_clk;
    logic i_rst_n;

    pclut_in_if  in_if();
    pclut_out_if out_if();

    palette_port_clut #(
        .ENTRIES(CLUT_ENTRIES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // shadow copy of the palette and upload state
    logic [ENTRY_W-1:0] palette_shadow [CLUT_ENTRIES];
    logic [PIX_W-1:0]   shadow_index;
    logic               shadow_phase;
    logic [15:0]        shadow_green_blue;
    logic               shadow_loaded;

    t_colour_result expected_colours[$];

    int unsigned errors;
    int unsigned items_sent;
    int unsigned lookups_checked;
    int unsigned fallback_lookups;
    int unsigned entries_stored;
    int unsigned ignored_items;
    int unsigned quiet_cycles;
    int unsigned hold_left;
    int unsigned ready_gap_left;
    bit          no_idle;
    bit          stall_request;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // update the shadow state for one accepted transaction
    task automatic apply_bus_access(input logic [ACTION_W-1:0] act,
                                    input logic [VALUE_W-1:0] val);
        t_colour_result     colour;
        logic [PIX_W-1:0]   slot;
        logic [PIX_W-1:0]   pix;
        logic [ENTRY_W-1:0] entry;
        case (act)
            ACT_SET_INDEX: begin
                shadow_index = PIX_W'(val[7:0] % CLUT_ENTRIES);
                shadow_phase = 1'b0;
            end
            ACT_DATA: begin
                if (!shadow_phase) begin
                    shadow_green_blue = val;
                    shadow_phase      = 1'b1;
                end else begin
                    slot = PIX_W'(shadow_index % CLUT_ENTRIES);
                    palette_shadow[slot] = {val[7:0], shadow_green_blue};
                    shadow_index  = PIX_W'((slot + 1) % CLUT_ENTRIES);
                    shadow_phase  = 1'b0;
                    shadow_loaded = 1'b1;
                    entries_stored++;
                end
            end
            ACT_LOOKUP: begin
                pix = val[7:0];
                if (shadow_loaded) begin
                    entry = palette_shadow[PIX_W'(pix % CLUT_ENTRIES)];
                    colour.rgb565        = {entry[23:19], entry[15:10], entry[7:3]};
                    colour.from_fallback = 1'b0;
                end else begin
                    // rgb332-style colour spread over the 565 fields
                    colour.rgb565 = {pix[7:5], 2'b00, pix[4:2], 3'b000, pix[1:0], 3'b000};
                    colour.from_fallback = 1'b1;
                    fallback_lookups++;
                end
                expected_colours.push_back(colour);
            end
            default: begin
                ignored_items++;
            end
        endcase
    endtask

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.action <= act;
        in_if.value  <= val;
        do @(posedge i_clk); while (!in_if.ready);
        apply_bus_access(act, val);
        if (act != ACT_UNUSED) items_sent++;
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (expected_colours.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_fallback_lookups();
        send_item(ACT_LOOKUP, 16'h0000);
        send_item(ACT_LOOKUP, 16'hFFFF);
        send_item(ACT_LOOKUP, 16'h00A5);
        send_item(ACT_LOOKUP, 16'hC35A);
        send_item(ACT_UNUSED, 16'hFFFF);
        send_item(ACT_SET_INDEX, 16'hAB10);
        // half a pair must not mark the palette loaded
        send_item(ACT_DATA, 16'h1234);
        send_item(ACT_LOOKUP, 16'h0010);
        // index write drops the pending green/blue halfword
        send_item(ACT_SET_INDEX, 16'h0003);
        send_item(ACT_DATA, 16'hFFFF);
        send_item(ACT_DATA, 16'hFF80);
        send_item(ACT_LOOKUP, 16'h0003);
    endtask

    task automatic test_palette_extremes();
        send_item(ACT_SET_INDEX, 16'h00FF);
        send_item(ACT_DATA, 16'hFFFF);
        send_item(ACT_DATA, 16'hFFFF);
        // index wrapped to entry zero
        send_item(ACT_DATA, 16'h0000);
        send_item(ACT_DATA, 16'h0000);
        send_item(ACT_DATA, 16'h5A5A);
        send_item(ACT_DATA, 16'hFFC3);
        send_item(ACT_LOOKUP, 16'hFFFF);
        send_item(ACT_LOOKUP, 16'h0000);
        send_item(ACT_LOOKUP, 16'h0101);
        send_item(ACT_LOOKUP, 16'h8002);
        send_item(ACT_UNUSED, 16'h0000);
        send_item(ACT_LOOKUP, 16'h0003);
    endtask

    task automatic test_random_traffic();
        int unsigned target;
        int unsigned segment;
        int unsigned count;
        int unsigned k;
        logic [PIX_W-1:0] near;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            no_idle = ($urandom_range(0, 9) == 0);
            segment = $urandom_range(0, 99);
            if (segment < 15) begin
                send_item(ACT_SET_INDEX, 16'($urandom));
                count = $urandom_range(1, 6);
                for (k = 0; k < count; k++) begin
                    send_item(ACT_DATA, 16'($urandom));
                    send_item(ACT_DATA, 16'($urandom));
                end
            end else if (segment < 80) begin
                count = $urandom_range(1, 8);
                for (k = 0; k < count; k++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_item(ACT_LOOKUP, 16'($urandom));
                    end else begin
                        // aim at entries uploaded recently
                        near = shadow_index - 8'd1 - 8'($urandom_range(0, 7));
                        send_item(ACT_LOOKUP, {8'($urandom), near});
                    end
                end
            end else if (segment < 87) begin
                send_item(ACT_UNUSED, 16'($urandom));
            end else if (segment < 94) begin
                send_item(ACT_DATA, 16'($urandom));
            end else begin
                send_item(ACT_DATA, 16'($urandom));
                send_item(ACT_SET_INDEX, 16'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_backpressure();
        int unsigned k;
        no_idle       = 1'b1;
        stall_request = 1'b1;
        for (k = 0; k < BURST_LOOKUPS; k++) begin
            send_item(ACT_LOOKUP, 16'($urandom));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        errors           = 0;
        items_sent       = 0;
        lookups_checked  = 0;
        fallback_lookups = 0;
        entries_stored   = 0;
        ignored_items    = 0;
        no_idle          = 1'b0;
        stall_request    = 1'b0;
        foreach (palette_shadow[n]) palette_shadow[n] = '0;
        shadow_index      = '0;
        shadow_phase      = 1'b0;
        shadow_green_blue = '0;
        shadow_loaded     = 1'b0;

        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.action <= ACT_SET_INDEX;
        in_if.value  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fallback_lookups();
        test_palette_extremes();
        wait_drained();
        test_random_traffic();
        wait_drained();
        test_output_backpressure();
        wait_drained();

        $display("%0d transactions sent, %0d ignored; %0d palette entries stored",
                 items_sent, ignored_items, entries_stored);
        $display("%0d lookups checked, %0d of them on the rgb332 colour; %s %0d cycles",
                 lookups_checked, fallback_lookups, "output held off", STALL_CYCLES);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // output ready: random gaps, plus one long hold-off on request
    initial begin
        hold_left      = 0;
        ready_gap_left = 0;
        out_if.ready  <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_request) begin
                stall_request = 1'b0;
                hold_left     = STALL_CYCLES - 1;
                out_if.ready <= 1'b0;
            end else if (ready_gap_left > 0) begin
                out_if.ready <= 1'b0;
                ready_gap_left--;
            end else begin
                out_if.ready  <= 1'b1;
                ready_gap_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_colour_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_colours.size() == 0) begin
                $error("result with nothing expected: rgb565 %h from_fallback %b",
                       out_if.rgb565, out_if.from_fallback);
                errors++;
            end else begin
                want = expected_colours.pop_front();
                lookups_checked++;
                if (out_if.rgb565 !== want.rgb565) begin
                    $error("rgb565 expected %h actual %h", want.rgb565, out_if.rgb565);
                    errors++;
                end
                if (out_if.from_fallback !== want.from_fallback) begin
                    $error("from_fallback expected %b actual %b",
                           want.from_fallback, out_if.from_fallback);
                    errors++;
                end
            end
        end
    end

    initial quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles, %0d results outstanding",
                   quiet_cycles, expected_colours.size());
            $display("FAIL");
            $finish;
        end
    end

endmodule

`default_nettype wire
